[src/layer_stack_manager_top_defines.svh]
// ------------------------------------------------------------------------
// Layer stack manager assertion macros
// Shared property wrappers for the port-level checker.
// ------------------------------------------------------------------------
`ifndef LAYER_STACK_MANAGER_TOP_DEFINES_SVH
`define LAYER_STACK_MANAGER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lsm_pkg.sv]
// ------------------------------------------------------------------------
// Layer stack manager package
// Command codes, sequencer states, fixed widths and clipping helpers.
// ------------------------------------------------------------------------
package lsm_pkg;

    localparam int RW = 18;   // rectangle arithmetic width
    localparam int CW = 12;   // level clamp arithmetic width

    localparam logic [2:0] CMD_ALLOC   = 3'd0;
    localparam logic [2:0] CMD_SIZE    = 3'd1;
    localparam logic [2:0] CMD_LEVEL   = 3'd2;
    localparam logic [2:0] CMD_MOVE    = 3'd3;
    localparam logic [2:0] CMD_FREE    = 3'd4;
    localparam logic [2:0] CMD_REFRESH = 3'd5;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_REDRAW = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_EXEC  = 9'b000000010,
        ST_SHRD  = 9'b000000100,
        ST_SHWR  = 9'b000001000,
        ST_FIN   = 9'b000010000,
        ST_EMIT  = 9'b000100000,
        ST_EMIT2 = 9'b001000000,
        ST_ALLOC = 9'b010000000,
        ST_SPARE = 9'b100000000
    } t_state;

    function automatic logic signed [12:0] clip_lo(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] r;
        r = (v < 0) ? '0 : v;
        return r[12:0];
    endfunction

    function automatic logic signed [12:0] clip_hi(input logic signed [RW-1:0] v,
                                                   input logic [10:0] lim);
        logic signed [RW-1:0] l;
        logic signed [RW-1:0] r;
        l = signed'(RW'(lim));
        r = (v > l) ? l : v;
        return r[12:0];
    endfunction

endpackage

[src/layer_stack_manager_top.sv]
// ------------------------------------------------------------------------
// Layer stack manager
// Z-order table of display layers with clipped redraw requests.
// ------------------------------------------------------------------------
// Command channel: an item is taken at a clock edge with i_start high and
// o_busy low. Results appear on the o_ result ports for one cycle each,
// marked by o_strobe; o_last flags the final result of an item. The
// receiver cannot stall, so results are never held.
// Configuration: i_cfg_valid/o_cfg_ready write screen width (index 0) or
// screen height (index 1); o_cfg_ready is always high.
// Sequencing: allocate scans the use flags one layer per cycle up to the
// first free layer or the last one. Set size, move and refresh take an execute step.
// A level change or a free of a visible layer moves each table entry
// between the old and new level through the order memory (one read,
// one write back per entry), then writes its own entry and emits.
// One item is in work at a time.
// Reset: synchronous, active low; all layers free, stack empty, screen
// 320 x 200. Layer geometry reads as zero until first written. No
// clearing pass is needed.
// ------------------------------------------------------------------------
module layer_stack_manager_top
    import lsm_pkg::*;
#(
    parameter int MAX_LAYERS = 256,
    parameter int COORD_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_layer,
    input  logic signed [8:0]   i_level,
    input  logic signed [11:0]  i_pos_x,
    input  logic signed [11:0]  i_pos_y,
    input  logic signed [11:0]  i_end_x,
    input  logic signed [11:0]  i_end_y,
    input  logic [10:0]         i_box_width,
    input  logic [10:0]         i_box_height,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [10:0]         i_cfg_data,
    output logic                o_strobe,
    output logic                o_kind,
    output logic [7:0]          o_result_layer,
    output logic                o_ok,
    output logic signed [12:0]  o_left,
    output logic signed [12:0]  o_top_edge,
    output logic signed [12:0]  o_right,
    output logic signed [12:0]  o_bottom,
    output logic [8:0]          o_from_level,
    output logic                o_last
);

    localparam int LID_W  = $clog2(MAX_LAYERS);
    localparam int LVL_W  = LID_W + 2;
    localparam int ATTR_W = 2 * COORD_BITS + 22;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [LVL_W-1:0]      t_lvl;

    // memories
    logic [ATTR_W-1:0] attr_mem  [MAX_LAYERS];
    logic [LID_W-1:0]  order_mem [MAX_LAYERS];
    t_lvl              level_mem [MAX_LAYERS];

    logic [MAX_LAYERS-1:0] r_used;
    logic [MAX_LAYERS-1:0] r_attr_vld;

    t_state r_state, n_state;
    t_lvl   r_top;
    logic [10:0] r_scr_w, r_scr_h;

    logic [2:0]          r_cmd;
    logic [LID_W-1:0]    r_lid;
    logic signed [8:0]   r_level;
    logic signed [11:0]  r_pos_x, r_pos_y, r_end_x, r_end_y;
    logic [10:0]         r_box_w, r_box_h;

    logic [ATTR_W-1:0] r_attr_q;
    logic              r_vld_q;
    t_lvl              r_lvl_q;
    logic [LID_W-1:0]  r_ord_q;

    logic [LID_W-1:0] r_scan;
    t_lvl r_dst, r_stop, r_want;
    logic r_down, r_hide, r_two;

    logic signed [RW-1:0] r_ax0, r_ay0, r_ax1, r_ay1;
    logic signed [RW-1:0] r_bx0, r_by0, r_bx1, r_by1;
    logic [8:0] r_afrom, r_bfrom;

    // input-side decode
    logic [15:0]      w_lid16;
    logic [LID_W-1:0] w_in_lid;
    logic             w_lid_ok;
    logic             w_accept;
    assign w_lid16  = {8'b0, i_layer};
    assign w_in_lid = w_lid16[LID_W-1:0];
    assign w_lid_ok = (w_lid16 < 16'(MAX_LAYERS)) && r_used[w_in_lid];
    assign w_accept = i_start && (r_state == ST_IDLE);

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // current layer attributes, zero until first written
    logic [ATTR_W-1:0] w_attr;
    t_coord            a_left, a_top;
    logic [10:0]       a_w, a_h;
    assign w_attr = r_vld_q ? r_attr_q : '0;
    assign {a_left, a_top, a_w, a_h} = w_attr;

    t_coord w_nx, w_ny;
    assign w_nx = COORD_BITS'(r_pos_x);
    assign w_ny = COORD_BITS'(r_pos_y);

    logic signed [RW-1:0] w_x0, w_y0;
    assign w_x0 = RW'(a_left);
    assign w_y0 = RW'(a_top);

    // level clamp
    logic signed [CW-1:0] c_top, c_old, c_req, c_want;
    always_comb begin
        c_top = CW'(r_top);
        c_old = CW'(r_lvl_q);
        c_req = (r_cmd == CMD_FREE) ? -CW'(1) : CW'(r_level);
        c_want = c_req;
        if (c_want > c_top + 1) begin
            c_want = c_top + 1;
        end
        if (c_old >= 0 && c_want > c_top) begin
            c_want = c_top;
        end
        if (c_want < -1) begin
            c_want = -CW'(1);
        end
    end

    t_lvl w_want;
    assign w_want = LVL_W'(c_want);

    // shift source
    t_lvl             w_src;
    logic             w_more;
    logic [LID_W-1:0] w_ord_ra;
    assign w_src    = r_down ? (r_dst - t_lvl'(1)) : (r_dst + t_lvl'(1));
    assign w_more   = r_down ? (r_dst > r_stop) : (r_dst < r_stop);
    assign w_ord_ra = w_src[LID_W-1:0];

    // memory write controls
    logic              attr_we;
    logic [ATTR_W-1:0] attr_wd;
    logic              ord_we;
    logic [LID_W-1:0]  ord_wa, ord_wd;
    logic              lvl_we;
    logic [LID_W-1:0]  lvl_wa;
    t_lvl              lvl_wd;

    always_comb begin
        attr_we = 1'b0;
        attr_wd = w_attr;
        ord_we  = 1'b0;
        ord_wa  = r_dst[LID_W-1:0];
        ord_wd  = r_ord_q;
        lvl_we  = 1'b0;
        lvl_wa  = r_ord_q;
        lvl_wd  = r_dst;
        unique case (r_state)
            ST_EXEC: begin
                if (r_cmd == CMD_SIZE) begin
                    attr_we = 1'b1;
                    attr_wd = {a_left, a_top, r_box_w, r_box_h};
                end else if (r_cmd == CMD_MOVE) begin
                    attr_we = 1'b1;
                    attr_wd = {w_nx, w_ny, a_w, a_h};
                end
            end
            ST_SHWR: begin
                ord_we = 1'b1;
                lvl_we = 1'b1;
            end
            ST_FIN: begin
                lvl_we = 1'b1;
                lvl_wa = r_lid;
                if (r_hide) begin
                    lvl_wd = -t_lvl'(1);
                end else begin
                    lvl_wd = r_want;
                    ord_we = 1'b1;
                    ord_wa = r_want[LID_W-1:0];
                    ord_wd = r_lid;
                end
            end
            ST_ALLOC: begin
                if (!r_used[r_scan]) begin
                    lvl_we = 1'b1;
                    lvl_wa = r_scan;
                    lvl_wd = -t_lvl'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (attr_we) begin
            attr_mem[r_lid] <= attr_wd;
        end
        r_attr_q <= attr_mem[w_in_lid];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        r_ord_q <= order_mem[w_ord_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            level_mem[lvl_wa] <= lvl_wd;
        end
        r_lvl_q <= level_mem[w_in_lid];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_cmd == CMD_ALLOC) begin
                        n_state = ST_ALLOC;
                    end else if (i_cmd <= CMD_REFRESH && w_lid_ok) begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                unique case (r_cmd)
                    CMD_MOVE, CMD_REFRESH: begin
                        if (r_lvl_q >= 0) begin
                            n_state = ST_EMIT;
                        end
                    end
                    CMD_LEVEL, CMD_FREE: begin
                        if (c_want != c_old && !(r_cmd == CMD_FREE && r_lvl_q < 0)) begin
                            n_state = ST_SHRD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHRD:  n_state = w_more ? ST_SHWR : ST_FIN;
            ST_SHWR:  n_state = ST_SHRD;
            ST_FIN:   n_state = ST_EMIT;
            ST_EMIT:  n_state = r_two ? ST_EMIT2 : ST_IDLE;
            ST_EMIT2: n_state = ST_IDLE;
            ST_ALLOC: begin
                if (!r_used[r_scan] || r_scan == LID_W'(MAX_LAYERS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_top      <= -t_lvl'(1);
            r_used     <= '0;
            r_attr_vld <= '0;
            r_scr_w    <= 11'd320;
            r_scr_h    <= 11'd200;
            r_vld_q    <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_vld_q  <= r_attr_vld[w_in_lid];
            o_strobe <= (r_state == ST_ALLOC &&
                         (!r_used[r_scan] || r_scan == LID_W'(MAX_LAYERS - 1))) ||
                        r_state == ST_EMIT || r_state == ST_EMIT2;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_scr_w <= i_cfg_data;
                    CFG_HEIGHT: r_scr_h <= i_cfg_data;
                endcase
            end
            if (attr_we) begin
                r_attr_vld[r_lid] <= 1'b1;
            end
            if (r_state == ST_EXEC && r_cmd == CMD_FREE) begin
                r_used[r_lid] <= 1'b0;
            end
            if (r_state == ST_EXEC && n_state == ST_SHRD) begin
                // hiding removes one entry, showing a hidden layer adds one
                if (c_want < 0) begin
                    r_top <= r_top - t_lvl'(1);
                end else if (c_old < 0) begin
                    r_top <= r_top + t_lvl'(1);
                end
            end
            if (r_state == ST_ALLOC && !r_used[r_scan]) begin
                r_used[r_scan] <= 1'b1;
            end
        end
    end

    // payload registers
    logic [15:0] w_scan16;
    assign w_scan16 = {{(16 - LID_W){1'b0}}, r_scan};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_cmd;
            r_lid   <= w_in_lid;
            r_level <= i_level;
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
            r_end_x <= i_end_x;
            r_end_y <= i_end_y;
            r_box_w <= i_box_width;
            r_box_h <= i_box_height;
            r_scan  <= '0;
        end
        if (r_state == ST_EXEC) begin
            r_two <= (r_cmd == CMD_MOVE);
            r_bx0 <= RW'(w_nx);
            r_by0 <= RW'(w_ny);
            r_bx1 <= RW'(w_nx) + RW'(a_w);
            r_by1 <= RW'(w_ny) + RW'(a_h);
            r_bfrom <= 9'(r_lvl_q);
            r_want  <= w_want;
            r_hide  <= (c_want < 0);
            if (r_cmd == CMD_REFRESH) begin
                r_ax0 <= w_x0 + RW'(r_pos_x);
                r_ay0 <= w_y0 + RW'(r_pos_y);
                r_ax1 <= w_x0 + RW'(r_end_x);
                r_ay1 <= w_y0 + RW'(r_end_y);
            end else begin
                r_ax0 <= w_x0;
                r_ay0 <= w_y0;
                r_ax1 <= w_x0 + RW'(a_w);
                r_ay1 <= w_y0 + RW'(a_h);
            end
            if (r_cmd == CMD_MOVE) begin
                r_afrom <= '0;
            end else if (r_cmd == CMD_REFRESH) begin
                r_afrom <= 9'(r_lvl_q);
            end else if (c_old > c_want) begin
                if (c_want >= 0) begin
                    // lower: open a gap at the new level
                    r_down  <= 1'b1;
                    r_dst   <= r_lvl_q;
                    r_stop  <= w_want;
                    r_afrom <= 9'(c_want + 1);
                end else begin
                    // hide: close the gap above the old level
                    r_down  <= 1'b0;
                    r_dst   <= r_lvl_q;
                    r_stop  <= r_top;
                    r_afrom <= '0;
                end
            end else begin
                r_afrom <= 9'(c_want);
                if (c_old >= 0) begin
                    r_down <= 1'b0;
                    r_dst  <= r_lvl_q;
                    r_stop <= w_want;
                end else begin
                    r_down <= 1'b1;
                    r_dst  <= r_top + t_lvl'(1);
                    r_stop <= w_want;
                end
            end
        end
        if (r_state == ST_SHWR) begin
            r_dst <= w_src;
        end
        if (r_state == ST_ALLOC) begin
            r_scan <= r_scan + LID_W'(1);
            o_kind         <= KIND_ALLOC;
            o_ok           <= !r_used[r_scan];
            o_result_layer <= r_used[r_scan] ? 8'd0 : w_scan16[7:0];
            o_left         <= '0;
            o_top_edge     <= '0;
            o_right        <= '0;
            o_bottom       <= '0;
            o_from_level   <= '0;
            o_last         <= 1'b1;
        end
        if (r_state == ST_EMIT) begin
            o_kind         <= KIND_REDRAW;
            o_ok           <= 1'b0;
            o_result_layer <= '0;
            o_left         <= clip_lo(r_ax0);
            o_top_edge     <= clip_lo(r_ay0);
            o_right        <= clip_hi(r_ax1, r_scr_w);
            o_bottom       <= clip_hi(r_ay1, r_scr_h);
            o_from_level   <= r_afrom;
            o_last         <= !r_two;
        end
        if (r_state == ST_EMIT2) begin
            o_kind         <= KIND_REDRAW;
            o_ok           <= 1'b0;
            o_result_layer <= '0;
            o_left         <= clip_lo(r_bx0);
            o_top_edge     <= clip_lo(r_by0);
            o_right        <= clip_hi(r_bx1, r_scr_w);
            o_bottom       <= clip_hi(r_by1, r_scr_h);
            o_from_level   <= r_bfrom;
            o_last         <= 1'b1;
        end
    end

endmodule

[src/lsm_checker.sv]
// ------------------------------------------------------------------------
// Layer stack manager port checker
// Watches result ordering and allocation answers on the top-level ports.
// ------------------------------------------------------------------------
`include "layer_stack_manager_top_defines.svh"

module lsm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_strobe,
    input logic        o_kind,
    input logic        o_ok,
    input logic [7:0]  o_result_layer,
    input logic        o_last
);

    `LSM_ASSERT_NOW(a_alloc_last, o_strobe && !o_kind, o_last, "allocation answer not last")
    `LSM_ASSERT_NOW(a_fail_zero, o_strobe && !o_kind && !o_ok, o_result_layer == 8'd0, "failed allocation names a layer")
    `LSM_ASSERT_NEXT(a_pair, o_strobe && !o_last, o_strobe && o_last && o_kind, "move pair broken")
    `LSM_ASSERT_NEXT(a_no_early, i_start && !o_busy, !o_strobe, "result in cycle after item taken")

endmodule

bind layer_stack_manager_top lsm_checker u_lsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_strobe       (o_strobe),
    .o_kind         (o_kind),
    .o_ok           (o_ok),
    .o_result_layer (o_result_layer),
    .o_last         (o_last)
);

[tb/sv/layer_stack_manager_top_test.sv]
// ------------------------------------------------------------------------
// Layer stack manager testbench
// Drives allocate, resize, restack, move, free and refresh commands with
// random gaps, tracks the layer table in a local copy and checks every
// allocation answer and clipped redraw request as it leaves the block.
// ------------------------------------------------------------------------
module layer_stack_manager_top_test;
    import lsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]         cmd;
        logic [7:0]         layer;
        logic signed [8:0]  level;
        logic signed [11:0] pos_x;
        logic signed [11:0] pos_y;
        logic signed [11:0] end_x;
        logic signed [11:0] end_y;
        logic [10:0]        box_w;
        logic [10:0]        box_h;
    } t_cmd;

    typedef struct {
        logic               kind;
        logic [7:0]         rlayer;
        logic               ok;
        logic signed [12:0] left;
        logic signed [12:0] top_edge;
        logic signed [12:0] right;
        logic signed [12:0] bottom;
        logic [8:0]         from_level;
        logic               last;
    } t_answer;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [2:0]         i_cmd;
    logic [7:0]         i_layer;
    logic signed [8:0]  i_level;
    logic signed [11:0] i_pos_x;
    logic signed [11:0] i_pos_y;
    logic signed [11:0] i_end_x;
    logic signed [11:0] i_end_y;
    logic [10:0]        i_box_width;
    logic [10:0]        i_box_height;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [10:0]        i_cfg_data;
    logic               o_strobe;
    logic               o_kind;
    logic [7:0]         o_result_layer;
    logic               o_ok;
    logic signed [12:0] o_left;
    logic signed [12:0] o_top_edge;
    logic signed [12:0] o_right;
    logic signed [12:0] o_bottom;
    logic [8:0]         o_from_level;
    logic               o_last;

    layer_stack_manager_top u_top (.*);

    // local copy of the layer table
    bit                 used_q[256];
    int                 level_q[256];
    int                 left_q[256];
    int                 top_q[256];
    int                 width_q[256];
    int                 height_q[256];
    int                 order_q[256];
    int                 top_level_q;
    int                 scr_w;
    int                 scr_h;

    t_cmd               cmd_queue[$];
    t_answer            answers_due[$];
    t_cmd               cur;
    int                 idle_pct;
    int                 errors;
    int                 items_taken;
    int                 answers_seen;
    int                 quiet_cycles;

    always #1 i_clk = ~i_clk;

    task automatic emit_redraw(int x0, int y0, int x1, int y1, int from, bit last);
        t_answer a;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > scr_w) x1 = scr_w;
        if (y1 > scr_h) y1 = scr_h;
        a.kind = KIND_REDRAW;
        a.rlayer = '0;
        a.ok = 1'b0;
        a.left = x0[12:0];
        a.top_edge = y0[12:0];
        a.right = x1[12:0];
        a.bottom = y1[12:0];
        a.from_level = from[8:0];
        a.last = last;
        answers_due.push_back(a);
    endtask

    task automatic put_slot(int h, int id);
        if (h >= 0 && h < 256) begin
            order_q[h] = id;
            level_q[id] = h;
        end
    endtask

    function automatic int slot_at(int h);
        return (h >= 0 && h < 256) ? order_q[h] : 0;
    endfunction

    task automatic restack(int id, int want);
        int old, h, x0, y0, x1, y1;
        old = level_q[id];
        x0 = left_q[id];
        y0 = top_q[id];
        x1 = x0 + width_q[id];
        y1 = y0 + height_q[id];
        if (want > top_level_q + 1) want = top_level_q + 1;
        // a visible layer can only go as high as the current top
        if (old >= 0 && want > top_level_q) want = top_level_q;
        if (want < -1) want = -1;
        if (want == old) return;
        if (old > want) begin
            if (want >= 0) begin
                for (h = old; h > want; h--) put_slot(h, slot_at(h - 1));
                put_slot(want, id);
                emit_redraw(x0, y0, x1, y1, want + 1, 1'b1);
            end else begin
                for (h = old; h < top_level_q; h++) put_slot(h, slot_at(h + 1));
                top_level_q--;
                level_q[id] = -1;
                emit_redraw(x0, y0, x1, y1, 0, 1'b1);
            end
        end else begin
            if (old >= 0) begin
                for (h = old; h < want; h++) put_slot(h, slot_at(h + 1));
                put_slot(want, id);
            end else begin
                for (h = top_level_q; h >= want; h--) put_slot(h + 1, slot_at(h));
                put_slot(want, id);
                top_level_q++;
            end
            emit_redraw(x0, y0, x1, y1, want, 1'b1);
        end
    endtask

    task automatic stack_apply(t_cmd c);
        t_answer a;
        int id, ox, oy;
        id = c.layer;
        if (c.cmd == CMD_ALLOC) begin
            a = '{default: '0};
            a.kind = KIND_ALLOC;
            a.last = 1'b1;
            for (int i = 0; i < 256; i++) begin
                if (!used_q[i]) begin
                    used_q[i] = 1'b1;
                    level_q[i] = -1;
                    a.rlayer = i[7:0];
                    a.ok = 1'b1;
                    break;
                end
            end
            answers_due.push_back(a);
            return;
        end
        if (c.cmd > CMD_REFRESH || !used_q[id]) return;
        case (c.cmd)
            CMD_SIZE: begin
                width_q[id] = c.box_w;
                height_q[id] = c.box_h;
            end
            CMD_LEVEL: restack(id, c.level);
            CMD_MOVE: begin
                ox = left_q[id];
                oy = top_q[id];
                left_q[id] = c.pos_x;
                top_q[id] = c.pos_y;
                if (level_q[id] >= 0) begin
                    emit_redraw(ox, oy, ox + width_q[id], oy + height_q[id], 0, 1'b0);
                    emit_redraw(left_q[id], top_q[id], left_q[id] + width_q[id],
                                top_q[id] + height_q[id], level_q[id], 1'b1);
                end
            end
            CMD_FREE: begin
                if (level_q[id] >= 0) restack(id, -1);
                used_q[id] = 1'b0;
            end
            default: begin
                if (level_q[id] >= 0)
                    emit_redraw(left_q[id] + c.pos_x, top_q[id] + c.pos_y,
                                left_q[id] + c.end_x, top_q[id] + c.end_y,
                                level_q[id], 1'b1);
            end
        endcase
    endtask

    task automatic report(string field, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d (answer %0d)",
                 field, got, want, answers_seen);
        errors++;
    endtask

    // driver: hold an item until taken, then fetch the next one or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                stack_apply(cur);
                items_taken++;
            end
            if ((i_start && !o_busy) || !i_start) begin
                if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    cur = cmd_queue.pop_front();
                    i_cmd <= cur.cmd;
                    i_layer <= cur.layer;
                    i_level <= cur.level;
                    i_pos_x <= cur.pos_x;
                    i_pos_y <= cur.pos_y;
                    i_end_x <= cur.end_x;
                    i_end_y <= cur.end_y;
                    i_box_width <= cur.box_w;
                    i_box_height <= cur.box_h;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_strobe) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
                report("unexpected answer", 1, 0);
            end else begin
                e = answers_due.pop_front();
                if (o_kind !== e.kind) report("kind", o_kind, e.kind);
                if (o_result_layer !== e.rlayer) report("layer", o_result_layer, e.rlayer);
                if (o_ok !== e.ok) report("ok", o_ok, e.ok);
                if (o_left !== e.left) report("left", o_left, e.left);
                if (o_top_edge !== e.top_edge) report("top", o_top_edge, e.top_edge);
                if (o_right !== e.right) report("right", o_right, e.right);
                if (o_bottom !== e.bottom) report("bottom", o_bottom, e.bottom);
                if (o_from_level !== e.from_level)
                    report("from_level", o_from_level, e.from_level);
                if (o_last !== e.last) report("last", o_last, e.last);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 6000) begin
            $display("timeout: no progress in %0d cycles", quiet_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_cmd mk(logic [2:0] op, int id, int lvl = 0, int px = 0,
                                int py = 0, int ex = 0, int ey = 0, int w = 0,
                                int h = 0);
        t_cmd c;
        c.cmd = op;
        c.layer = id[7:0];
        c.level = lvl[8:0];
        c.pos_x = px[11:0];
        c.pos_y = py[11:0];
        c.end_x = ex[11:0];
        c.end_y = ey[11:0];
        c.box_w = w[10:0];
        c.box_h = h[10:0];
        return c;
    endfunction

    function automatic t_cmd random_cmd(int max_id);
        t_cmd c;
        int r;
        r = $urandom_range(0, 99);
        c.cmd = r < 14 ? CMD_ALLOC : r < 28 ? CMD_SIZE : r < 58 ? CMD_LEVEL :
                r < 72 ? CMD_MOVE : r < 82 ? CMD_FREE : r < 97 ? CMD_REFRESH :
                3'($urandom_range(6, 7));
        c.layer = $urandom_range(0, 99) < 88 ? 8'($urandom_range(0, max_id)) : 8'($urandom);
        r = $urandom_range(0, 99);
        c.level = r < 60 ? 9'(int'($urandom_range(0, 15)) - 2) :
                  r < 80 ? 9'($urandom) : -9'sd1;
        if ($urandom_range(0, 99) < 75) begin
            c.pos_x = 12'(int'($urandom_range(0, 600)) - 150);
            c.pos_y = 12'(int'($urandom_range(0, 400)) - 100);
            c.end_x = 12'(int'($urandom_range(0, 600)) - 150);
            c.end_y = 12'(int'($urandom_range(0, 400)) - 100);
            c.box_w = 11'($urandom_range(0, 250));
            c.box_h = 11'($urandom_range(0, 250));
        end else begin
            c.pos_x = 12'($urandom);
            c.pos_y = 12'($urandom);
            c.end_x = 12'($urandom);
            c.end_y = 12'($urandom);
            c.box_w = 11'($urandom);
            c.box_h = 11'($urandom);
        end
        return c;
    endfunction

    task automatic drain();
        while (cmd_queue.size() > 0 || i_start || answers_due.size() > 0)
            @(posedge i_clk);
        // an item that yields no answer may still be running
        repeat (2 * 256 + 20) @(posedge i_clk);
    endtask

    task automatic write_screen(logic idx, int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[10:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_WIDTH) scr_w = val; else scr_h = val;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int widths[5] = '{320, 1, 2047, 97, 640};
        int heights[5] = '{200, 2047, 1, 150, 480};
        int idles[4] = '{0, 62, 0, 17};
        i_clk = 0;
        i_rst_n = 0;
        i_start = 0;
        i_cmd = '0; i_layer = '0; i_level = '0;
        i_pos_x = '0; i_pos_y = '0; i_end_x = '0; i_end_y = '0;
        i_box_width = '0; i_box_height = '0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = '0;
        errors = 0; items_taken = 0; answers_seen = 0; quiet_cycles = 0;
        idle_pct = 0;
        scr_w = 320; scr_h = 200; top_level_q = -1;
        foreach (used_q[i]) begin
            used_q[i] = 0; level_q[i] = 0; left_q[i] = 0; top_q[i] = 0;
            width_q[i] = 0; height_q[i] = 0; order_q[i] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and corner cases
        cmd_queue.push_back(mk(CMD_ALLOC, 0));
        cmd_queue.push_back(mk(CMD_ALLOC, 0));
        cmd_queue.push_back(mk(CMD_ALLOC, 0));
        cmd_queue.push_back(mk(CMD_MOVE, 0, 0, 2047, 2047));          // hidden: stored only
        cmd_queue.push_back(mk(CMD_REFRESH, 0));                      // hidden: nothing
        cmd_queue.push_back(mk(CMD_SIZE, 0, 0, 0, 0, 0, 0, 2047, 2047));
        cmd_queue.push_back(mk(CMD_SIZE, 1, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(mk(CMD_LEVEL, 0, 255));
        cmd_queue.push_back(mk(CMD_LEVEL, 1, 255));
        cmd_queue.push_back(mk(CMD_LEVEL, 2, 0));
        cmd_queue.push_back(mk(CMD_LEVEL, 0, 255));                   // visible, clamped
        cmd_queue.push_back(mk(CMD_LEVEL, 0, 2));                     // same level
        cmd_queue.push_back(mk(CMD_LEVEL, 1, -256));                  // clamp to hidden
        cmd_queue.push_back(mk(CMD_MOVE, 0, 0, -2048, -2048));
        cmd_queue.push_back(mk(CMD_REFRESH, 0, 0, 2047, 2047, -2048, -2048)); // crossed
        cmd_queue.push_back(mk(CMD_REFRESH, 0, 0, -2048, -2048, 2047, 2047));
        cmd_queue.push_back(mk(CMD_REFRESH, 200));                    // unused layer
        cmd_queue.push_back(mk(3'd6, 0));
        cmd_queue.push_back(mk(3'd7, 255, -1, -1, -1, -1, -1, 2047, 2047));
        cmd_queue.push_back(mk(CMD_FREE, 1));                         // hidden free
        cmd_queue.push_back(mk(CMD_FREE, 0));                         // visible free
        cmd_queue.push_back(mk(CMD_LEVEL, 2, -1));
        cmd_queue.push_back(mk(CMD_FREE, 2));
        drain();

        for (int p = 0; p < 8; p++) begin
            write_screen(CFG_WIDTH, widths[p % 5]);
            write_screen(CFG_HEIGHT, heights[p % 5]);
            idle_pct = idles[p % 4];
            if (p == 3) begin
                // fill the table, overflow it, shuffle deep, then release
                for (int i = 0; i < 258; i++) cmd_queue.push_back(mk(CMD_ALLOC, 0));
                for (int i = 0; i < 60; i++)
                    cmd_queue.push_back(mk(CMD_LEVEL, $urandom_range(0, 255),
                                           $urandom_range(0, 260) - 1));
                for (int i = 0; i < 256; i++)
                    cmd_queue.push_back(mk($urandom_range(0, 3) == 0 ? CMD_REFRESH :
                                           CMD_FREE, i, 0, 0, 0, 50, 50));
                for (int i = 0; i < 256; i++) cmd_queue.push_back(mk(CMD_FREE, i));
            end else begin
                for (int i = 0; i < 143; i++) cmd_queue.push_back(random_cmd(11));
            end
            drain();
        end
        write_screen(CFG_WIDTH, 320);
        write_screen(CFG_HEIGHT, 200);

        $display("%0d commands issued, %0d answers checked over 8 screen sizes",
                 items_taken, answers_seen);
        if (errors == 0 && answers_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[layer_stack_manager_top.f]
+incdir+src
src/lsm_pkg.sv
src/layer_stack_manager_top.sv
src/lsm_checker.sv
tb/sv/layer_stack_manager_top_test.sv
